// File: rtl/assert_macros.svh
// Assertion macros shared by the wav header parser RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wav_hp_pkg.sv
// Package for the wav header parser: payload structs, search phases,
// tags, offsets and configuration register indexes. No dependencies.
`default_nettype none

package wav_hp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CHANNELS = 1'd1;

  localparam logic [30:0] BUFFER_LENGTH_RESET    = 31'd0;
  localparam logic [7:0]  DEFAULT_CHANNELS_RESET = 8'd1;

  localparam int DEFAULT_DATA_SEARCH_LIMIT = 196;

  // Window tags, oldest byte in the top lane
  localparam logic [31:0] TAG_RIFF     = 32'h52494646;
  localparam logic [31:0] TAG_WAVE     = 32'h57415645;
  localparam logic [31:0] TAG_FMT_SIZE = 32'h10000000;
  localparam logic [31:0] TAG_DATA     = 32'h64617461;

  localparam int MIN_BUFFER_LENGTH = 44;
  localparam int RIFF_START_LIMIT  = 1;
  localparam int WAVE_START_LIMIT  = 8;
  localparam int FMT_START_LIMIT   = 16;
  localparam int WINDOW_SPAN       = 3;

  localparam int CHAN_OFFSET     = 6;
  localparam int RATE_OFFSET     = 8;
  localparam int RATE_LAST       = 11;
  localparam int SIZE_OFFSET     = 4;
  localparam int SIZE_LAST       = 7;
  localparam int PAYLOAD_HDR_LEN = 8;

  localparam int FMT_POS_W = 5;

  localparam logic [7:0] STEREO = 8'd2;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_WAVE,
    PH_FMT,
    PH_DATA,
    PH_TAIL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } wav_in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  channel_count;
    logic [31:0] sample_rate;
    logic [7:0]  payload_offset;
    logic [30:0] payload_length;
  } wav_out_t;

endpackage

`default_nettype wire

// File: rtl/wav_hp_in_reg.sv
// Input register of the wav header parser: holds one accepted byte.
// Depends on wav_hp_pkg.
`default_nettype none

module wav_hp_in_reg
  import wav_hp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire wav_in_t in_data,
  input  wire logic    advance,
  output logic         item_valid,
  output wav_in_t      item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wav_hp_core.sv
// Header search and field capture for the wav header parser.
// Depends on wav_hp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wav_hp_core
  import wav_hp_pkg::*;
#(
  parameter int DATA_SEARCH_LIMIT = DEFAULT_DATA_SEARCH_LIMIT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire wav_in_t     item,
  input  wire logic [30:0] buffer_length,
  input  wire logic [7:0]  default_channels,
  output logic             res_valid,
  output wav_out_t         res
);

  localparam int POS_W = $clog2(DATA_SEARCH_LIMIT + PAYLOAD_HDR_LEN + 1);
  localparam int SUM_W = POS_W + 1;
  localparam int OFF_W = ((POS_W > 8) ? POS_W : 8) + 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  phase_t               phase, phase_next;
  logic [POS_W-1:0]     pos, pos_next;
  logic [23:0]          hist;
  logic [FMT_POS_W-1:0] fmt_pos, fmt_pos_next;
  logic [POS_W-1:0]     data_pos, data_pos_next;
  logic [31:0]          rate_word, rate_next;
  logic [31:0]          chunk_size, chunk_next;
  logic [7:0]           chan_byte, chan_next;

  logic [7:0]       b;
  logic [31:0]      win;
  logic             full;
  logic [POS_W-1:0] s;
  logic [SUM_W-1:0] nx, fx, dx, rate_diff, size_diff;
  logic             short_buf;
  logic             fields_open;
  logic             chan_hit, rate_hit, size_hit, tail_done;
  logic             report, fail;
  logic [OFF_W-1:0] off_sum;
  logic [30:0]      len_clamped;

  assign b         = item.data_byte;
  assign win       = {hist, b};
  assign full      = pos >= POS_W'(WINDOW_SPAN);
  assign s         = full ? pos - POS_W'(WINDOW_SPAN) : '0;
  assign short_buf = buffer_length < 31'(MIN_BUFFER_LENGTH);

  assign nx        = {1'b0, pos};
  assign fx        = SUM_W'(fmt_pos);
  assign dx        = {1'b0, data_pos};
  assign rate_diff = nx - fx;
  assign size_diff = nx - dx;

  assign fields_open = (phase == PH_DATA) || (phase == PH_TAIL);
  assign chan_hit    = fields_open && (nx == fx + SUM_W'(CHAN_OFFSET));
  assign rate_hit    = fields_open && (nx >= fx + SUM_W'(RATE_OFFSET))
                       && (nx <= fx + SUM_W'(RATE_LAST));
  assign size_hit    = (phase == PH_TAIL) && (nx >= dx + SUM_W'(SIZE_OFFSET))
                       && (nx <= dx + SUM_W'(SIZE_LAST));
  assign tail_done   = (nx >= fx + SUM_W'(RATE_LAST)) && (nx >= dx + SUM_W'(SIZE_LAST));

  // Little-endian byte lanes; both offsets are multiples of four
  always_comb begin
    rate_next  = rate_word;
    chunk_next = chunk_size;
    for (int i = 0; i < 4; i++) begin
      if (rate_hit && (rate_diff[1:0] == 2'(i))) begin
        rate_next[8*i +: 8] = b;
      end
      if (size_hit && (size_diff[1:0] == 2'(i))) begin
        chunk_next[8*i +: 8] = b;
      end
    end
  end

  assign chan_next   = chan_hit ? b : chan_byte;
  assign off_sum     = OFF_W'(data_pos) + OFF_W'(PAYLOAD_HDR_LEN);
  assign len_clamped = (chunk_next > {1'b0, buffer_length}) ? buffer_length
                                                            : chunk_next[30:0];

  // Search sequence
  always_comb begin
    phase_next    = phase;
    fmt_pos_next  = fmt_pos;
    data_pos_next = data_pos;
    report        = 1'b0;
    fail          = 1'b0;
    if (phase != PH_DONE && pos == '0 && short_buf) begin
      report = 1'b1;
      fail   = 1'b1;
    end else begin
      case (phase)
        PH_RIFF: begin
          if (full) begin
            if (win == TAG_RIFF) begin
              phase_next = PH_WAVE;
            end else if (s >= POS_W'(RIFF_START_LIMIT)) begin
              report = 1'b1;
              fail   = 1'b1;
            end
          end
        end
        PH_WAVE: begin
          if (win == TAG_WAVE) begin
            phase_next = PH_FMT;
          end else if (s >= POS_W'(WAVE_START_LIMIT)) begin
            report = 1'b1;
            fail   = 1'b1;
          end
        end
        PH_FMT: begin
          if (win == TAG_FMT_SIZE) begin
            fmt_pos_next = s[FMT_POS_W-1:0];
            phase_next   = PH_DATA;
          end else if (s >= POS_W'(FMT_START_LIMIT)) begin
            report = 1'b1;
            fail   = 1'b1;
          end
        end
        PH_DATA: begin
          if (win == TAG_DATA) begin
            data_pos_next = s;
            phase_next    = PH_TAIL;
          end else if (s >= POS_W'(DATA_SEARCH_LIMIT)) begin
            report = 1'b1;
            fail   = 1'b1;
          end
        end
        PH_TAIL: begin
          if (tail_done) begin
            report = 1'b1;
            fail   = short_buf;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_RIFF;
        end
      endcase
    end
    if (report) begin
      phase_next = PH_DONE;
    end
    // Buffer ran out before any report: fail now
    if (item.end_of_buffer && phase != PH_DONE && !report) begin
      report = 1'b1;
      fail   = 1'b1;
    end
    if (item.end_of_buffer) begin
      phase_next = PH_RIFF;
    end
  end

  assign pos_next = item.end_of_buffer ? '0 : ((pos == POS_MAX) ? pos : pos + 1'b1);

  // Result fields
  always_comb begin
    res = '0;
    res.status = 1'b1;
    if (!fail) begin
      res.status         = 1'b0;
      res.channel_count  = (chan_next == STEREO) ? STEREO : default_channels;
      res.sample_rate    = rate_next;
      res.payload_offset = off_sum[7:0];
      res.payload_length = len_clamped;
    end
  end

  assign res_valid = report;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      pos   <= '0;
    end else if (advance) begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hist       <= {hist[15:0], b};
      fmt_pos    <= fmt_pos_next;
      data_pos   <= data_pos_next;
      rate_word  <= rate_next;
      chunk_size <= chunk_next;
      chan_byte  <= chan_next;
    end
  end

  `ASSERT_IMPLIES(a_no_second_report, advance && res_valid && !item.end_of_buffer, phase != PH_DONE, "report issued twice for one buffer")
  `ASSERT_IMPLIES(a_len_clamped, advance && res_valid && !res.status, res.payload_length <= buffer_length, "payload length exceeds buffer length")
  `ASSERT_NEXT(a_rearm, advance && item.end_of_buffer, phase == PH_RIFF && pos == '0, "end of buffer did not rearm the search")

endmodule

`default_nettype wire

// File: rtl/wav_hp_out_reg.sv
// Result register of the wav header parser: holds one report until taken.
// Depends on wav_hp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wav_hp_out_reg
  import wav_hp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire wav_out_t res,
  output logic          out_valid,
  input  wire logic     out_ready,
  output wav_out_t      out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  `ASSERT_IMPLIES(a_no_overwrite, load, !out_valid || out_ready, "pending report overwritten")

endmodule

`default_nettype wire

// File: rtl/wav_header_parser.sv
// WAV header parser top level: config registers, input register, search core
// and result register. Depends on wav_hp_pkg, wav_hp_in_reg, wav_hp_core, wav_hp_out_reg.
//
// Usage:
//   Feed the buffer one byte per transfer on in_data, offset zero first, with
//   end_of_buffer set on the final byte. At most one report per buffer comes
//   out on out_data: status 0 with channel count, sample rate, payload offset
//   and clamped payload length, or status 1 with the other fields zero.
//   Bytes after the report are dropped until end_of_buffer, which rearms the
//   search for the next buffer; configuration is kept.
//   Write buffer_length and default_channels through cfg_we/cfg_index/cfg_data
//   while no byte is in flight.
// Timing:
//   One byte per cycle while no report waits. A byte taken into the input
//   register is evaluated and its report loaded into the result register once
//   that register is free. While a report waits, one more byte is taken; then
//   in_ready drops until out_ready takes the report.
// Reset: rst (synchronous) empties both registers, restarts the search and
//   sets buffer_length to 0 and default_channels to 1.
`default_nettype none

module wav_header_parser
  import wav_hp_pkg::*;
#(
  parameter int DATA_SEARCH_LIMIT = DEFAULT_DATA_SEARCH_LIMIT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire wav_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output wav_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [30:0] buffer_length;
  logic [7:0]  default_channels;
  logic        item_valid;
  wav_in_t     item;
  logic        advance;
  logic        res_valid;
  wav_out_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length    <= BUFFER_LENGTH_RESET;
      default_channels <= DEFAULT_CHANNELS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUFFER_LENGTH:    buffer_length    <= cfg_data[30:0];
        CFG_DEFAULT_CHANNELS: default_channels <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Evaluate the held byte only when the result register can take a report
  assign advance = item_valid && (!out_valid || out_ready);

  wav_hp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wav_hp_core #(
    .DATA_SEARCH_LIMIT (DATA_SEARCH_LIMIT)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .item             (item),
    .buffer_length    (buffer_length),
    .default_channels (default_channels),
    .res_valid        (res_valid),
    .res              (res)
  );

  wav_hp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
